/* hdl/delayed_sinc_pulse_player_core_assert.svh */
// assertion macros shared by the pulse player modules
`ifndef DELAYED_SINC_PULSE_PLAYER_CORE_ASSERT_SVH
`define DELAYED_SINC_PULSE_PLAYER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DSPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define DSPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dspp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dspp_pkg;

	// pulse table
	localparam int TABLE_DEPTH = 4096;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);

	// field widths
	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 12;
	localparam int SAMP_W  = 16;
	localparam int DELAY_W = 14;
	localparam int RATIO_W = 13;
	localparam int SPP_W   = 13;
	localparam int AMP_W   = 15;

	// table length in use and the dividend of the modulo unit
	localparam int LEN_W     = RATIO_W + SPP_W;
	localparam int MOD_W     = LEN_W + 1;
	localparam int MOD_CNT_W = $clog2(MOD_W + 1);

	// full-scale amplitude
	localparam int FULL_SCALE = 32'h7FFF;

	// stream widths
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 2 * SAMP_W;

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// apb port
	localparam int APB_DW    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = PADDR_W - 2;

	// item modes
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EMIT  = 2'd2;

	// pulse kinds
	localparam logic KIND_TRANSMIT = 1'b0;
	localparam logic KIND_TEMPLATE = 1'b1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RATIO = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPP   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AMP   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_I_EN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KIND  = 3'd4;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [SPP_W-1:0]   spp;
		logic [AMP_W-1:0]   amp;
		logic               i_en;
		logic               kind;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		ratio: 13'd1,
		spp:   13'd64,
		amp:   15'h7FFF,
		i_en:  1'b1,
		kind:  KIND_TRANSMIT
	};

	typedef struct packed {
		logic [MODE_W-1:0]  kind;
		logic [ADDR_W-1:0]  addr;
		logic [SAMP_W-1:0]  re;
		logic [SAMP_W-1:0]  im;
		logic [DELAY_W-1:0] dly;
	} cmd_t;

endpackage

`default_nettype wire

/* hdl/dspp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "delayed_sinc_pulse_player_core_assert.svh"

module dspp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dspp_pkg::cmd_t       push_cmd,
	output logic                 full,
	output logic                 avail,
	output dspp_pkg::cmd_t       head_cmd,
	input  logic                 pop
);

	dspp_pkg::cmd_t                 slot_q [dspp_pkg::FIFO_DEPTH];
	logic [dspp_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [dspp_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [dspp_pkg::FIFO_CW-1:0]   cnt_q;

	// occupancy flags
	assign full     = cnt_q == dspp_pkg::FIFO_CW'(dspp_pkg::FIFO_DEPTH);
	assign avail    = cnt_q != '0;
	assign head_cmd = slot_q[rd_ptr_q];

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + dspp_pkg::FIFO_CW'(push) - dspp_pkg::FIFO_CW'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	`DSPP_ASSERT_NOW(a_push_full, clk, arst_n, push, !full, "queue written while full")
	`DSPP_ASSERT_NOW(a_pop_empty, clk, arst_n, pop, avail, "queue read while empty")
	`DSPP_ASSERT_NEXT(a_cnt_step, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + dspp_pkg::FIFO_CW'(1), "queue count did not step")

endmodule

`default_nettype wire

/* hdl/dspp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dspp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// table_address, entry_real, entry_imag, delay, zero fill
	input  logic [dspp_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode
	input  logic [dspp_pkg::MODE_W-1:0]      s_tuser,
	output logic                             push,
	output dspp_pkg::cmd_t                   push_cmd,
	input  logic                             full
);

	logic             hld_vld_q;
	dspp_pkg::cmd_t   hld_cmd_q;
	logic             take;
	logic             keep;

	// hold register drains into the queue
	assign s_tready = !hld_vld_q || !full;
	assign take     = s_tvalid && s_tready;
	assign push     = hld_vld_q && !full;
	assign push_cmd = hld_cmd_q;

	// unused mode is accepted and dropped
	always_comb begin
		unique case (s_tuser)
			dspp_pkg::MODE_LOAD,
			dspp_pkg::MODE_START,
			dspp_pkg::MODE_EMIT: keep = 1'b1;
			default:             keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hld_vld_q <= 1'b0;
		end else if (s_tready) begin
			hld_vld_q <= take && keep;
		end
	end

	// unpack the transfer
	always_ff @(posedge clk) begin
		if (take) begin
			hld_cmd_q.kind <= s_tuser;
			hld_cmd_q.addr <= s_tdata[dspp_pkg::ADDR_W-1:0];
			hld_cmd_q.re   <= s_tdata[dspp_pkg::ADDR_W +: dspp_pkg::SAMP_W];
			hld_cmd_q.im   <= s_tdata[dspp_pkg::ADDR_W + dspp_pkg::SAMP_W +: dspp_pkg::SAMP_W];
			hld_cmd_q.dly  <= s_tdata[dspp_pkg::ADDR_W + 2 * dspp_pkg::SAMP_W +: dspp_pkg::DELAY_W];
		end
	end

endmodule

`default_nettype wire

/* hdl/dspp_mod.sv */
`timescale 1ns / 1ps
`default_nettype none

module dspp_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [dspp_pkg::MOD_W-1:0]     dividend,
	input  logic [dspp_pkg::LEN_W-1:0]     divisor,
	output logic                           done,
	output logic [dspp_pkg::LEN_W-1:0]     rem
);

	logic                               busy_q;
	logic                               done_q;
	logic [dspp_pkg::MOD_CNT_W-1:0]     cnt_q;
	logic [dspp_pkg::MOD_W-1:0]         dvd_q;
	logic [dspp_pkg::LEN_W-1:0]         rem_q;
	logic [dspp_pkg::LEN_W:0]           trial;
	logic [dspp_pkg::LEN_W:0]           diff;

	assign done = done_q;
	assign rem  = rem_q;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, dvd_q[dspp_pkg::MOD_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == dspp_pkg::MOD_CNT_W'(1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= dspp_pkg::MOD_CNT_W'(dspp_pkg::MOD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dspp_pkg::MOD_CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[dspp_pkg::LEN_W] ? trial[dspp_pkg::LEN_W-1:0]
			                               : diff[dspp_pkg::LEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hdl/dspp_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module dspp_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [dspp_pkg::SAMP_W-1:0] in_i,
	input  logic signed [dspp_pkg::SAMP_W-1:0] in_q,
	input  logic                               in_last,
	input  logic [dspp_pkg::AMP_W-1:0]         amp,
	output logic                               adv,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// i_sample, q_sample
	output logic [dspp_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                               m_tlast
);

	localparam int PROD_W = dspp_pkg::SAMP_W + dspp_pkg::AMP_W + 1;
	localparam int Q_W    = dspp_pkg::SAMP_W + 1;

	logic signed [dspp_pkg::AMP_W:0]    amp_s;
	logic                               vld_s2;
	logic                               last_s2;
	logic signed [PROD_W-1:0]           prod_i_s2;
	logic signed [PROD_W-1:0]           prod_q_s2;
	logic                               vld_s3;
	logic                               last_s3;
	logic [dspp_pkg::SAMP_W-1:0]        i_s3;
	logic [dspp_pkg::SAMP_W-1:0]        q_s3;

	// product over 32767 truncated toward zero: split at 2^15 and fix up the remainder
	function automatic logic [dspp_pkg::SAMP_W-1:0] div_full_scale(
		input logic signed [PROD_W-1:0] p
	);
		logic [PROD_W-1:0] mag;
		logic [Q_W-1:0]    q1;
		logic [Q_W-1:0]    r1;
		logic [Q_W-1:0]    q;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		q1  = Q_W'(mag >> dspp_pkg::AMP_W);
		r1  = Q_W'(mag[dspp_pkg::AMP_W-1:0]) + q1;
		priority if (r1 >= Q_W'(2 * dspp_pkg::FULL_SCALE)) q = q1 + Q_W'(2);
		else if (r1 >= Q_W'(dspp_pkg::FULL_SCALE))        q = q1 + Q_W'(1);
		else                                               q = q1;
		return p[PROD_W-1] ? dspp_pkg::SAMP_W'(-q) : dspp_pkg::SAMP_W'(q);
	endfunction

	// whole pipeline moves unless the output register is held
	assign adv      = !vld_s3 || m_tready;
	assign amp_s    = $signed({1'b0, amp});
	assign m_tvalid = vld_s3;
	assign m_tlast  = last_s3;
	assign m_tdata  = {q_s3, i_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
		end
	end

	// multiply, then divide by full scale
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_i_s2 <= in_i * amp_s;
			prod_q_s2 <= in_q * amp_s;
			last_s2   <= in_last;
			i_s3      <= div_full_scale(prod_i_s2);
			q_s3      <= div_full_scale(prod_q_s2);
			last_s3   <= last_s2;
		end
	end

endmodule

`default_nettype wire

/* hdl/dspp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "delayed_sinc_pulse_player_core_assert.svh"

module dspp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dspp_pkg::cfg_t                      cfg,
	input  logic                                cmd_avail,
	input  dspp_pkg::cmd_t                      cmd,
	output logic                                pop,
	input  logic                                adv,
	output logic                                smp_vld_s1,
	output logic signed [dspp_pkg::SAMP_W-1:0]  smp_i_s1,
	output logic signed [dspp_pkg::SAMP_W-1:0]  smp_q_s1,
	output logic                                smp_last_s1
);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WRAP  = 2'd2;

	logic [1:0]                          st_q;

	// pulse table
	logic signed [dspp_pkg::SAMP_W-1:0]  real_mem [dspp_pkg::TABLE_DEPTH];
	logic signed [dspp_pkg::SAMP_W-1:0]  imag_mem [dspp_pkg::TABLE_DEPTH];

	logic [dspp_pkg::RATIO_W-1:0]        ratio_e;
	logic [dspp_pkg::SPP_W-1:0]          spp_e;
	logic [dspp_pkg::LEN_W-1:0]          len_q;

	// pointers
	logic [dspp_pkg::SPP_W-1:0]          count_q;
	logic [dspp_pkg::TAB_AW-1:0]         dir_q;
	logic                                dir_far_q;
	logic [dspp_pkg::LEN_W-1:0]          dly_q;
	logic [dspp_pkg::LEN_W-1:0]          start_q;
	logic                                neg_q;

	logic                                is_load;
	logic                                is_start;
	logic                                is_emit;
	logic                                fin;
	logic                                wr_en;
	logic [dspp_pkg::TAB_AW-1:0]         wr_addr;
	logic [dspp_pkg::TAB_AW-1:0]         dly_addr;
	logic [dspp_pkg::LEN_W-1:0]          dir_sum;
	logic                                dir_far_nx;
	logic                                dly_in;
	logic [dspp_pkg::MOD_W-1:0]          dly_sum;
	logic [dspp_pkg::MOD_W-1:0]          len_ext;
	logic [dspp_pkg::LEN_W-1:0]          dly_nx;
	logic signed [dspp_pkg::DELAY_W:0]   neg_dly;
	logic [dspp_pkg::DELAY_W:0]          mag_dly;

	logic                                mod_go;
	logic                                mod_done;
	logic [dspp_pkg::MOD_W-1:0]          mod_dvd;
	logic [dspp_pkg::LEN_W-1:0]          mod_rem;
	logic [dspp_pkg::LEN_W-1:0]          start_res;

	// read stage
	logic                                vld_s1;
	logic                                last_s1;
	logic                                dir_zero_s1;
	logic                                dly_zero_s1;
	logic signed [dspp_pkg::SAMP_W-1:0]  re_dir_s1;
	logic signed [dspp_pkg::SAMP_W-1:0]  re_dly_s1;
	logic signed [dspp_pkg::SAMP_W-1:0]  im_dir_s1;

	// zero ratio or length counts as one
	assign ratio_e = (cfg.ratio == '0) ? dspp_pkg::RATIO_W'(1) : cfg.ratio;
	assign spp_e   = (cfg.spp == '0) ? dspp_pkg::SPP_W'(1) : cfg.spp;

	always_ff @(posedge clk) begin
		len_q <= ratio_e * spp_e;
	end

	// command decode
	assign pop      = cmd_avail && adv && (st_q == ST_RUN);
	assign is_load  = cmd.kind == dspp_pkg::MODE_LOAD;
	assign is_start = cmd.kind == dspp_pkg::MODE_START;
	assign is_emit  = cmd.kind == dspp_pkg::MODE_EMIT;
	assign wr_en    = pop && is_load && (32'(cmd.addr) < 32'(dspp_pkg::TABLE_DEPTH));
	assign wr_addr  = dspp_pkg::TAB_AW'(cmd.addr);

	// last sample of the pulse
	assign fin = ({1'b0, count_q} + 1'b1) >= {1'b0, spp_e};

	// direct pointer, sticky once past the table
	assign dir_sum    = dspp_pkg::LEN_W'(dir_q) + dspp_pkg::LEN_W'(ratio_e);
	assign dir_far_nx = dir_far_q || (dir_sum >= dspp_pkg::LEN_W'(dspp_pkg::TABLE_DEPTH));

	// delayed pointer: one subtract while it stays below the length, else the modulo unit
	assign dly_in   = dly_q < len_q;
	assign len_ext  = dspp_pkg::MOD_W'(len_q);
	assign dly_sum  = dspp_pkg::MOD_W'(dly_q) + dspp_pkg::MOD_W'(ratio_e);
	assign dly_nx   = (dly_sum >= len_ext) ? dspp_pkg::LEN_W'(dly_sum - len_ext)
	                                       : dspp_pkg::LEN_W'(dly_sum);
	assign dly_addr = dly_q[dspp_pkg::TAB_AW-1:0];

	// start offset is the negated delay reduced modulo the length
	assign neg_dly   = -$signed({cmd.dly[dspp_pkg::DELAY_W-1], cmd.dly});
	assign mag_dly   = neg_dly[dspp_pkg::DELAY_W] ? (dspp_pkg::DELAY_W + 1)'(-neg_dly)
	                                              : (dspp_pkg::DELAY_W + 1)'(neg_dly);
	assign start_res = (neg_q && (mod_rem != '0)) ? len_q - mod_rem : mod_rem;

	assign mod_go  = pop && (is_start || (is_emit && !fin && !dly_in));
	assign mod_dvd = is_start ? dspp_pkg::MOD_W'(mag_dly) : dly_sum;

	dspp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (mod_dvd),
		.divisor  (len_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// sequencer and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_RUN;
			count_q   <= '0;
			dir_q     <= '0;
			dir_far_q <= 1'b0;
			dly_q     <= '0;
			start_q   <= '0;
			neg_q     <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			if (adv) vld_s1 <= pop && is_emit;
			unique case (st_q)
				ST_RUN: begin
					if (pop && is_start) begin
						count_q   <= '0;
						dir_q     <= '0;
						dir_far_q <= 1'b0;
						neg_q     <= neg_dly[dspp_pkg::DELAY_W];
						st_q      <= ST_START;
					end else if (pop && is_emit) begin
						if (fin) begin
							count_q   <= '0;
							dir_q     <= '0;
							dir_far_q <= 1'b0;
							dly_q     <= start_q;
						end else begin
							count_q   <= count_q + 1'b1;
							dir_q     <= dir_sum[dspp_pkg::TAB_AW-1:0];
							dir_far_q <= dir_far_nx;
							if (dly_in) dly_q <= dly_nx;
							else st_q <= ST_WRAP;
						end
					end
				end
				ST_START: begin
					if (mod_done) begin
						start_q <= start_res;
						dly_q   <= start_res;
						st_q    <= ST_RUN;
					end
				end
				ST_WRAP: begin
					if (mod_done) begin
						dly_q <= mod_rem;
						st_q  <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// table write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			real_mem[wr_addr] <= cmd.re;
			imag_mem[wr_addr] <= cmd.im;
		end
		if (adv) begin
			re_dir_s1   <= real_mem[dir_q];
			re_dly_s1   <= real_mem[dly_addr];
			im_dir_s1   <= imag_mem[dir_q];
			last_s1     <= fin;
			dir_zero_s1 <= dir_far_q;
			dly_zero_s1 <= dly_q >= dspp_pkg::LEN_W'(dspp_pkg::TABLE_DEPTH);
		end
	end

	// pick the entries for I and Q
	always_comb begin
		unique case (cfg.kind)
			dspp_pkg::KIND_TEMPLATE: begin
				smp_i_s1 = dir_zero_s1 ? '0 : re_dir_s1;
				smp_q_s1 = dir_zero_s1 ? '0 : im_dir_s1;
			end
			dspp_pkg::KIND_TRANSMIT: begin
				smp_i_s1 = (cfg.i_en && !dir_zero_s1) ? re_dir_s1 : '0;
				smp_q_s1 = dly_zero_s1 ? '0 : re_dly_s1;
			end
		endcase
	end

	assign smp_vld_s1  = vld_s1;
	assign smp_last_s1 = last_s1;

	`DSPP_ASSERT_NOW(a_no_pop_busy, clk, arst_n, st_q != ST_RUN, !pop, "command taken while modulo runs")
	`DSPP_ASSERT_NEXT(a_start_waits, clk, arst_n, pop && is_start, st_q == ST_START, "start did not wait for offset")
	`DSPP_ASSERT_NOW(a_done_in_wait, clk, arst_n, mod_done, (st_q == ST_START) || (st_q == ST_WRAP), "modulo result with nobody waiting")
	`DSPP_ASSERT_NEXT(a_fin_restart, clk, arst_n, pop && is_emit && fin, (count_q == '0) && !dir_far_q, "pulse did not restart after last sample")

endmodule

`default_nettype wire

/* hdl/delayed_sinc_pulse_player_core.sv */
// an emit item passes the hold register, the queue, read stage s1 and scale stages s2, s3
// throughput: one load or emit item per cycle while the output is not held;
//   a start item holds the back end for the bit-serial modulo of the offset (27 steps)
// so does an emit after a length change that leaves the delayed pointer past the length
// reset: control and pointers clear at once, config to defaults; table garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module delayed_sinc_pulse_player_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// table_address, entry_real, entry_imag, delay, zero fill
	input  logic [dspp_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode
	input  logic [dspp_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// i_sample, q_sample
	output logic [dspp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dspp_pkg::PADDR_W-1:0]     paddr,
	input  logic [dspp_pkg::APB_DW-1:0]      pwdata,
	output logic [dspp_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	dspp_pkg::cfg_t                     cfg_q;
	logic                               cfg_wr;
	logic [dspp_pkg::REG_IDX_W-1:0]     reg_idx;

	logic                               push;
	dspp_pkg::cmd_t                     push_cmd;
	logic                               full;
	logic                               avail;
	dspp_pkg::cmd_t                     head_cmd;
	logic                               pop;
	logic                               adv;
	logic                               smp_vld_s1;
	logic signed [dspp_pkg::SAMP_W-1:0] smp_i_s1;
	logic signed [dspp_pkg::SAMP_W-1:0] smp_q_s1;
	logic                               smp_last_s1;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[dspp_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= dspp_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dspp_pkg::REG_RATIO: cfg_q.ratio <= pwdata[dspp_pkg::RATIO_W-1:0];
				dspp_pkg::REG_SPP:   cfg_q.spp   <= pwdata[dspp_pkg::SPP_W-1:0];
				dspp_pkg::REG_AMP:   cfg_q.amp   <= pwdata[dspp_pkg::AMP_W-1:0];
				dspp_pkg::REG_I_EN:  cfg_q.i_en  <= pwdata[0];
				dspp_pkg::REG_KIND:  cfg_q.kind  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dspp_pkg::REG_RATIO: prdata = dspp_pkg::APB_DW'(cfg_q.ratio);
			dspp_pkg::REG_SPP:   prdata = dspp_pkg::APB_DW'(cfg_q.spp);
			dspp_pkg::REG_AMP:   prdata = dspp_pkg::APB_DW'(cfg_q.amp);
			dspp_pkg::REG_I_EN:  prdata = dspp_pkg::APB_DW'(cfg_q.i_en);
			dspp_pkg::REG_KIND:  prdata = dspp_pkg::APB_DW'(cfg_q.kind);
			default:             prdata = '0;
		endcase
	end

	// front end: take and classify items
	dspp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	// command queue
	dspp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.avail    (avail),
		.head_cmd (head_cmd),
		.pop      (pop)
	);

	// back end: table, pointers and reads
	dspp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_avail   (avail),
		.cmd         (head_cmd),
		.pop         (pop),
		.adv         (adv),
		.smp_vld_s1  (smp_vld_s1),
		.smp_i_s1    (smp_i_s1),
		.smp_q_s1    (smp_q_s1),
		.smp_last_s1 (smp_last_s1)
	);

	// amplitude scaling and output register
	dspp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (smp_vld_s1),
		.in_i     (smp_i_s1),
		.in_q     (smp_q_s1),
		.in_last  (smp_last_s1),
		.amp      (cfg_q.amp),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
